@@ hdl/rmf_pkg.sv @@
// ----------------------------------------------------------------------------
// rmf_pkg
// Shared types and constants of the rgb 3x3 median filter: pixel layout,
// configuration register codes and default frame limits.
// ----------------------------------------------------------------------------
package rmf_pkg;

  // channel and pixel layout
  localparam int CHAN_W   = 8;
  localparam int WIN_SIZE = 9;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  localparam int PIXEL_W = $bits(pixel_t);

  // one channel of the 3x3 window
  typedef logic [WIN_SIZE-1:0][CHAN_W-1:0] chan_win_t;

  // configuration port
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  // frame size limits
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int MIN_DIM        = 3;

endpackage

@@ hdl/rmf_line_store.sv @@
// ----------------------------------------------------------------------------
// rmf_line_store
// One row of pixels: single write port, single read port with registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module rmf_line_store
  import rmf_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_WIDTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  pixel_t            wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output pixel_t            rd_data
);

  pixel_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/rmf_median9.sv @@
// ----------------------------------------------------------------------------
// rmf_median9
// Median of nine 8-bit values by a 19 compare-exchange selection network.
// ----------------------------------------------------------------------------
module rmf_median9
  import rmf_pkg::*;
(
  input  chan_win_t         taps,
  output logic [CHAN_W-1:0] median
);

  // put the smaller value at position a, the larger at position b
  function automatic chan_win_t cx(input chan_win_t v, input int a, input int b);
    chan_win_t r;
    r = v;
    if (v[a] > v[b]) begin
      r[a] = v[b];
      r[b] = v[a];
    end
    return r;
  endfunction

  chan_win_t p;

  // selection network, result lands in the middle slot
  always_comb begin
    p = taps;
    p = cx(p, 1, 2);
    p = cx(p, 4, 5);
    p = cx(p, 7, 8);
    p = cx(p, 0, 1);
    p = cx(p, 3, 4);
    p = cx(p, 6, 7);
    p = cx(p, 1, 2);
    p = cx(p, 4, 5);
    p = cx(p, 7, 8);
    p = cx(p, 0, 3);
    p = cx(p, 5, 8);
    p = cx(p, 4, 7);
    p = cx(p, 3, 6);
    p = cx(p, 1, 4);
    p = cx(p, 2, 5);
    p = cx(p, 4, 7);
    p = cx(p, 4, 2);
    p = cx(p, 6, 4);
    p = cx(p, 4, 2);
  end

  assign median = p[4];

endmodule

@@ hdl/rgb_median_filter_3x3_unit.sv @@
// ----------------------------------------------------------------------------
// rgb_median_filter_3x3_unit
// Streaming 3x3 median filter for rgb pixels in raster order.
// ----------------------------------------------------------------------------
// Input channel: one pixel per beat (red_in, green_in, blue_in), valid/stall.
// Output channel: one beat per interior pixel of the frame, carrying the
// per-channel median of its 3x3 neighbourhood; frame_last marks the last
// interior pixel. Border pixels are consumed and give no output beat.
// Configuration: cfg_we/cfg_index/cfg_data write image_width (index 0) or
// image_height (index 1); either write restarts the frame at row 0, col 0.
// Write only while the block is idle. Sizes are clamped to 3..MAX_*.
// Throughput: one pixel per cycle while the output does not stall. An
// output beat passes the input register (with the line store reads),
// then the window register, then the output register. The output beat
// describes the pixel one row up and one column left of the input that
// completed its window.
// Reset: counters clear, window clears, sizes return to 640 x 480; the line
// stores are not cleared and need no clearing pass.
// Stall: out_stall holds the output register; the pipeline fills behind it
// and in_stall rises once the input stage cannot move on.
// ----------------------------------------------------------------------------
module rgb_median_filter_3x3_unit
  import rmf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // pixel input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CHAN_W-1:0]      red_in,
  input  logic [CHAN_W-1:0]      green_in,
  input  logic [CHAN_W-1:0]      blue_in,
  // median output
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CHAN_W-1:0]      red_median,
  output logic [CHAN_W-1:0]      green_median,
  output logic [CHAN_W-1:0]      blue_median,
  output logic                   frame_last
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // configuration registers
  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic                    cfg_hit;

  // frame position
  logic [COL_W-1:0] col_count, col_next, col_last;
  logic [ROW_W-1:0] row_count, row_next, row_last;

  // input stage
  logic             in_accept;
  logic             a_valid, a_adv;
  pixel_t           a_pix;
  logic [COL_W-1:0] a_col;
  logic             a_emit, a_last;
  pixel_t           upper_rd, middle_rd;

  // window stage
  pixel_t window [WIN_SIZE];
  logic   w_valid, w_last, w_adv;

  // output stage
  logic      out_ready;
  chan_win_t red_win, green_win, blue_win;
  logic [CHAN_W-1:0] red_med, green_med, blue_med;

  // register writes
  assign cfg_hit = cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped last column and last row
  always_comb begin
    if (32'(image_width) < MIN_DIM) begin
      col_last = COL_W'(MIN_DIM - 1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_W'(32'(image_width) - 1);
    end
    if (32'(image_height) < MIN_DIM) begin
      row_last = ROW_W'(MIN_DIM - 1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      row_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      row_last = ROW_W'(32'(image_height) - 1);
    end
  end

  // handshake and stage movement
  assign out_ready = !out_valid || !out_stall;
  assign w_adv     = w_valid && out_ready;
  assign a_adv     = a_valid && (!w_valid || out_ready);
  assign in_stall  = a_valid && !a_adv;
  assign in_accept = in_valid && !in_stall;

  // raster position of the next beat
  always_comb begin
    col_next = col_count;
    row_next = row_count;
    if (col_count == col_last) begin
      col_next = '0;
      if (row_count == row_last) begin
        row_next = '0;
      end else begin
        row_next = row_count + ROW_W'(1);
      end
    end else begin
      col_next = col_count + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (cfg_hit) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_accept) begin
      col_count <= col_next;
      row_count <= row_next;
    end
  end

  // input stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_accept) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_pix  <= '{red: red_in, green: green_in, blue: blue_in};
      a_col  <= col_count;
      a_emit <= (32'(row_count) >= 2) && (32'(col_count) >= 2);
      a_last <= (row_count == row_last) && (col_count == col_last);
    end
  end

  // line stores: read at accept, written back as the beat enters the window
  rmf_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_upper_store (
    .clk     (clk),
    .wr_en   (a_adv),
    .wr_addr (a_col),
    .wr_data (middle_rd),
    .rd_en   (in_accept),
    .rd_addr (col_count),
    .rd_data (upper_rd)
  );

  rmf_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_middle_store (
    .clk     (clk),
    .wr_en   (a_adv),
    .wr_addr (a_col),
    .wr_data (a_pix),
    .rd_en   (in_accept),
    .rd_addr (col_count),
    .rd_data (middle_rd)
  );

  // 3x3 window shift, column 2 is newest
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_SIZE; i++) begin
        window[i] <= '0;
      end
    end else if (a_adv) begin
      for (int r = 0; r < 3; r++) begin
        window[r*3]     <= window[r*3 + 1];
        window[r*3 + 1] <= window[r*3 + 2];
      end
      window[2] <= upper_rd;
      window[5] <= middle_rd;
      window[8] <= a_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
      w_last  <= 1'b0;
    end else if (a_adv) begin
      w_valid <= a_emit;
      w_last  <= a_last;
    end else if (w_adv) begin
      w_valid <= 1'b0;
    end
  end

  // split window by channel
  always_comb begin
    for (int i = 0; i < WIN_SIZE; i++) begin
      red_win[i]   = window[i].red;
      green_win[i] = window[i].green;
      blue_win[i]  = window[i].blue;
    end
  end

  rmf_median9 u_red_med   (.taps(red_win),   .median(red_med));
  rmf_median9 u_green_med (.taps(green_win), .median(green_med));
  rmf_median9 u_blue_med  (.taps(blue_win),  .median(blue_med));

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= w_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (w_adv) begin
      red_median   <= red_med;
      green_median <= green_med;
      blue_median  <= blue_med;
      frame_last   <= w_last;
    end
  end

`ifndef ASSERT_OFF
  // raster counters never pass the clamped frame size
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    col_count <= col_last)
    else $error("column counter beyond last column");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    row_count <= row_last)
    else $error("row counter beyond last row");

  // a blocked window beat is never overwritten
  a_window_held: assert property (@(posedge clk) disable iff (rst)
    w_valid && !out_ready |=> w_valid)
    else $error("window beat lost while output stalled");

  // end-of-frame flag only on an interior pixel
  a_last_interior: assert property (@(posedge clk) disable iff (rst)
    a_valid && a_last |-> a_emit)
    else $error("frame end flagged on a border pixel");
`endif

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rgb 3x3 median filter unit.
// Pixels are pushed in raster order through the valid/stall input while
// the output side stalls at random. A scoreboard class tracks line stores,
// window and frame counters, works out the per-channel median for every
// interior pixel, and compares each output beat with the oldest pending one.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmf_pkg::*;

  // register indexes the block does not implement
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int WIN_DIM         = 3;
  localparam int LATENCY         = 2;
  localparam int GAP_MAX         = 14;
  localparam int LONG_HOLD       = 120;
  localparam int PRESSURE_PIXELS = 200;
  localparam int RANDOM_PIXELS   = 650;
  localparam int PROBE_PIXELS    = 60;

  typedef enum {PIX_UNIFORM, PIX_EXTREME, PIX_CLUSTER} pixel_style_t;

  typedef struct packed {
    pixel_t med;
    logic   last;
  } median_beat_t;

  // tracks the filter state and the median beats still owed by the block
  class median_scoreboard;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    pixel_t                  upper_row [DEF_MAX_WIDTH];
    pixel_t                  middle_row [DEF_MAX_WIDTH];
    pixel_t                  window [WIN_SIZE];
    logic [10:0]             col_pos;
    logic [11:0]             row_pos;
    median_beat_t            medians_due [$];
    int                      mismatches;
    int                      beats_checked;
    int                      frames_closed;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (window[i]) window[i] = '0;
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      col_pos       = '0;
      row_pos       = '0;
      mismatches    = 0;
      beats_checked = 0;
      frames_closed = 0;
    endfunction

    // sizes as the block uses them, clamped to the supported range
    function int frame_width();
      if (width_reg < MIN_DIM) return MIN_DIM;
      if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return int'(width_reg);
    endfunction

    function int frame_height();
      if (height_reg < MIN_DIM) return MIN_DIM;
      if (height_reg > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
      return int'(height_reg);
    endfunction

    // a write to a known register restarts the frame, stores stay
    function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_IMAGE_WIDTH: width_reg = data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_reg = data[HEIGHT_REG_W-1:0];
        default: return;
      endcase
      col_pos = '0;
      row_pos = '0;
    endfunction

    // fifth smallest of nine
    function logic [CHAN_W-1:0] median_of(chan_win_t c);
      logic [CHAN_W-1:0] v [WIN_SIZE];
      logic [CHAN_W-1:0] key;
      int j;
      for (int i = 0; i < WIN_SIZE; i++) v[i] = c[i];
      for (int i = 1; i < WIN_SIZE; i++) begin
        key = v[i];
        j = i - 1;
        while (j >= 0 && v[j] > key) begin
          v[j+1] = v[j];
          j--;
        end
        v[j+1] = key;
      end
      return v[WIN_SIZE/2];
    endfunction

    // advance the filter by one accepted pixel
    function void note_pixel(pixel_t pix);
      int           w, h, col, row;
      pixel_t       top, mid;
      chan_win_t    rw, gw, bw;
      median_beat_t beat;
      w   = frame_width();
      h   = frame_height();
      col = col_pos;
      row = row_pos;
      if (col >= w) col = 0;
      if (row >= h) row = 0;

      // line stores shift down one row at this column
      top = upper_row[col];
      mid = middle_row[col];
      upper_row[col]  = mid;
      middle_row[col] = pix;

      // window shifts left, newest column on the right
      for (int r = 0; r < WIN_DIM; r++) begin
        window[r*WIN_DIM]     = window[r*WIN_DIM + 1];
        window[r*WIN_DIM + 1] = window[r*WIN_DIM + 2];
      end
      window[WIN_DIM - 1]     = top;
      window[2*WIN_DIM - 1]   = mid;
      window[WIN_SIZE - 1]    = pix;

      // interior pixel: window is complete
      if (row >= 2 && col >= 2) begin
        for (int i = 0; i < WIN_SIZE; i++) begin
          rw[i] = window[i].red;
          gw[i] = window[i].green;
          bw[i] = window[i].blue;
        end
        beat.med.red   = median_of(rw);
        beat.med.green = median_of(gw);
        beat.med.blue  = median_of(bw);
        beat.last      = (row == h - 1) && (col == w - 1);
        medians_due.push_back(beat);
      end

      // raster counters with wrap at end of frame
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
      col_pos = 11'(col);
      row_pos = 12'(row);
    endfunction

    task flag_mismatch(string what, int got, int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
    endtask

    // compare one output beat with the oldest pending median
    task check_beat(pixel_t med, logic last);
      median_beat_t want;
      if (medians_due.size() == 0) begin
        flag_mismatch("beat with no pending median", 1, 0);
        return;
      end
      want = medians_due.pop_front();
      beats_checked++;
      if (med.red !== want.med.red) flag_mismatch("red_median", med.red, want.med.red);
      if (med.green !== want.med.green)
        flag_mismatch("green_median", med.green, want.med.green);
      if (med.blue !== want.med.blue) flag_mismatch("blue_median", med.blue, want.med.blue);
      if (last !== want.last) flag_mismatch("frame_last", last, want.last);
      if (want.last) frames_closed++;
    endtask
  endclass

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic [CHAN_W-1:0]      red_in    = '0;
  logic [CHAN_W-1:0]      green_in  = '0;
  logic [CHAN_W-1:0]      blue_in   = '0;
  logic                   out_stall = 1'b0;
  logic                   in_stall;
  logic                   out_valid;
  logic [CHAN_W-1:0]      red_median;
  logic [CHAN_W-1:0]      green_median;
  logic [CHAN_W-1:0]      blue_median;
  logic                   frame_last;

  median_scoreboard board;
  int  pixels_sent       = 0;
  int  cfg_writes        = 0;
  bit  send_idle         = 1'b1;
  bit  recv_idle         = 1'b1;
  int  long_hold_cycles  = 0;

  rgb_median_filter_3x3_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red_median   (red_median),
    .green_median (green_median),
    .blue_median  (blue_median),
    .frame_last   (frame_last)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap(bit enabled);
    return enabled ? int'($urandom_range(0, GAP_MAX)) : 0;
  endfunction

  function automatic pixel_t make_pixel(pixel_style_t style);
    pixel_t p;
    int     base;
    case (style)
      PIX_EXTREME: begin
        p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      PIX_CLUSTER: begin
        // narrow spread gives many ties in the sort
        base    = $urandom_range(0, 251);
        p.red   = 8'(base + $urandom_range(0, 4));
        p.green = 8'(base + $urandom_range(0, 4));
        p.blue  = 8'(base + $urandom_range(0, 4));
      end
      default: p = 24'($urandom);
    endcase
    return p;
  endfunction

  // one input beat after a random gap
  task automatic send_pixel(pixel_t pix);
    int gap;
    gap = pick_gap(send_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    red_in   <= pix.red;
    green_in <= pix.green;
    blue_in  <= pix.blue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_pixel(pix);
    pixels_sent++;
  endtask

  // stop sending until every pending median has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.medians_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(index, data);
    cfg_writes++;
  endtask

  // output side: random stall before each beat, one long hold on request
  initial begin
    int hold;
    while (rst) @(posedge clk);
    forever begin
      hold = pick_gap(recv_idle);
      if (long_hold_cycles > 0) begin
        hold = long_hold_cycles;
        long_hold_cycles = 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_beat({red_median, green_median, blue_median}, frame_last);
    end
  end

  // stimulus
  initial begin
    pixel_t                pix;
    pixel_style_t          style;
    logic [CFG_DATA_W-1:0] data;
    int                    n, pause_at, fw, fh, random_start, phase, cfg_pick;
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset sizes: the start of a default-width frame gives no beats
    send_idle = 1'b0;
    for (int i = 0; i < PROBE_PIXELS; i++) send_pixel(make_pixel(PIX_UNIFORM));
    send_idle = 1'b1;

    // sizes below the minimum clamp to 3x3, channel extremes
    write_reg(REG_IMAGE_WIDTH, '0);
    write_reg(REG_IMAGE_HEIGHT, 13'd1);
    for (int i = 0; i < WIN_SIZE; i++) begin
      pix.red   = i[0] ? 8'hFF : 8'h00;
      pix.green = 8'hFF - 8'(i * 31);
      pix.blue  = (i == WIN_SIZE / 2) ? 8'hFF : 8'(i);
      send_pixel(pix);
    end

    // next frame follows on; writes to unused indexes must not restart it
    for (int i = 0; i < 4; i++) send_pixel(make_pixel(PIX_EXTREME));
    write_reg(REG_SPARE_2, 13'h1FFF);
    write_reg(REG_SPARE_3, '0);
    for (int i = 0; i < 5; i++) send_pixel(make_pixel(PIX_UNIFORM));

    // width write mid-frame restarts it; bit 12 is outside the width register
    for (int i = 0; i < 3; i++) send_pixel(make_pixel(PIX_UNIFORM));
    write_reg(REG_IMAGE_WIDTH, 13'h1004);
    for (int i = 0; i < 12; i++) send_pixel(make_pixel(PIX_CLUSTER));

    // sizes above the maximum clamp; the long first row gives no beats
    write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
    send_idle = 1'b0;
    for (int i = 0; i < PROBE_PIXELS; i++) send_pixel(make_pixel(PIX_UNIFORM));

    // random phases of small frames
    random_start = pixels_sent;
    phase = 0;
    while (pixels_sent - random_start < RANDOM_PIXELS) begin
      phase++;
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      // the first phases always write a small width and mostly a small height so beats come out
      cfg_pick = (phase <= 2) ? 2 : int'($urandom_range(0, 7));
      case (cfg_pick)
        0: write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 13'($urandom));
        1: ;
        default: begin
          data = {1'($urandom_range(0, 1)), 12'($urandom_range(0, 10))};
          write_reg(REG_IMAGE_WIDTH, data);
          data = {($urandom_range(0, 7) == 0), 12'($urandom_range(0, 8))};
          write_reg(REG_IMAGE_HEIGHT, data);
        end
      endcase
      fw = board.frame_width();
      fh = board.frame_height();
      if (fh > 64) n = $urandom_range(20, 80);
      else begin
        n = fw * fh * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) n += $urandom_range(1, fw * fh - 1);
      end
      style = pixel_style_t'($urandom_range(0, 2));

      // back-to-back input against a long output hold fills the pipeline
      if (phase == 2) begin
        n = PRESSURE_PIXELS;
        send_idle = 1'b0;
        long_hold_cycles = LONG_HOLD;
      end
      pause_at = (phase == 1 || $urandom_range(0, 3) == 0) ? $urandom_range(1, n - 1) : -1;

      for (int k = 0; k < n; k++) begin
        if (k == pause_at) settle();
        send_pixel(make_pixel(style));
      end
    end

    // drain and let any stray beat show up
    settle();
    repeat (40) @(posedge clk);
    $display("Sent %0d pixels in %0d register settings; %0d median beats checked, %0d frame ends",
             pixels_sent, cfg_writes, board.beats_checked, board.frames_closed);
    $display("Clamped small and oversized frames, unused register writes, border skipping");
    $display("and frame wrap exercised under random and long output stalls");
    if (board.mismatches == 0 && board.medians_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Timeout with %0d median beats still pending", board.medians_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
hdl/rmf_pkg.sv
hdl/rmf_line_store.sv
hdl/rmf_median9.sv
hdl/rgb_median_filter_3x3_unit.sv
bench/tb.sv
